// ===== hdl/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// Precedence expression evaluator package
// Operator codes, pending-term codes and the control and status structs that
// pass between the top level and the serial multiply/divide unit.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_END = 3'd4;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_MUL  = 2'd1,
		PEND_DIV  = 2'd2
	} pend_t;

	typedef struct packed {
		logic start;
		logic div;
	} md_cmd_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} md_sts_t;

endpackage

// ===== hdl/pee_muldiv.sv =====
// ----------------------------------------------------------------------------
// Serial multiply/divide unit
// Signed fixed-point multiply by shift-and-add, one multiplier bit per cycle,
// and restoring divide, one quotient bit per cycle. Results are rounded
// toward zero and saturated; the divisor must be nonzero.
// ----------------------------------------------------------------------------
module pee_muldiv #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pee_pkg::md_cmd_t              cmd,
	input  logic signed [VALUE_WIDTH-1:0] a,
	input  logic signed [VALUE_WIDTH-1:0] b,
	output pee_pkg::md_sts_t              sts,
	output logic [VALUE_WIDTH-1:0]        result
);
	import pee_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int NW = VW + FB;
	localparam int PW = 2 * VW;
	localparam int QW = (PW - FB > NW) ? PW - FB : NW;
	localparam int CW = $clog2(NW);

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_RUN  = 3'b010,
		MD_FIN  = 3'b100
	} md_state_t;

	md_state_t       state_q;
	logic [CW-1:0]   cnt_q;
	logic            div_q;
	logic            neg_q;
	logic [VW-1:0]   opnd_q;
	logic [PW-1:0]   prod_q;
	logic [VW-1:0]   rem_q;
	logic [NW-1:0]   nq_q;

	logic [VW-1:0]   mag_a;
	logic [VW-1:0]   mag_b;
	logic [VW:0]     add_sum;
	logic [PW-1:0]   prod_next;
	logic [VW:0]     trial;
	logic [VW:0]     diff;
	logic            ge;
	logic [QW-1:0]   mag;
	logic            ovf;

	always_comb begin
		mag_a = a[VW-1] ? VW'(-a) : VW'(a);
		mag_b = b[VW-1] ? VW'(-b) : VW'(b);
		add_sum = {1'b0, prod_q[PW-1:VW]} + {1'b0, opnd_q};
		prod_next = prod_q[0] ? {add_sum, prod_q[VW-1:1]} : {1'b0, prod_q[PW-1:1]};
		trial = {rem_q, nq_q[NW-1]};
		diff = trial - {1'b0, opnd_q};
		ge = !diff[VW];
		mag = div_q ? QW'(nq_q) : QW'(prod_q >> FB);
		ovf = (|mag[QW-1:VW]) | (mag[VW-1] & (!neg_q | (|mag[VW-2:0])));
		if (ovf) begin
			result = neg_q ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end else begin
			result = neg_q ? VW'(-mag[VW-1:0]) : mag[VW-1:0];
		end
		sts.done = (state_q == MD_FIN);
		sts.ovf = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q <= '0;
			div_q <= 1'b0;
			neg_q <= 1'b0;
			opnd_q <= '0;
			prod_q <= '0;
			rem_q <= '0;
			nq_q <= '0;
		end else begin
			unique case (state_q)
				MD_IDLE: begin
					if (cmd.start) begin
						div_q <= cmd.div;
						neg_q <= a[VW-1] ^ b[VW-1];
						opnd_q <= mag_b;
						prod_q <= PW'(mag_a);
						rem_q <= '0;
						nq_q <= NW'(mag_a) << FB;
						cnt_q <= cmd.div ? CW'(NW - 1) : CW'(VW - 1);
						state_q <= MD_RUN;
					end
				end
				MD_RUN: begin
					if (div_q) begin
						rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
						nq_q <= {nq_q[NW-2:0], ge};
					end else begin
						prod_q <= prod_next;
					end
					if (cnt_q == '0) begin
						state_q <= MD_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				MD_FIN: begin
					state_q <= MD_IDLE;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/precedence_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// Precedence expression evaluator
// Evaluates an infix expression with two precedence levels, one operand and
// its following operator per input beat, in saturating signed fixed point.
// ----------------------------------------------------------------------------
// Steps: an operand after add, subtract or a zero divisor goes from idle straight
// to apply; after a multiply or divide it passes through calc, where the serial
// multiply/divide unit works one bit per cycle. The default widths give Q16.16.
// One beat is in work at a time; an end beat also waits for the output register
// to free, and a finished result waits there while the next beat is taken.
// Reset is asynchronous and clears the sum, the pending term and the flags.
module precedence_expression_evaluator_unit #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// operand_value
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
	// next_operator
	input  logic [2:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// result_value
	output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,
	// overflow_flag in bit 0, divide_by_zero in bit 1
	output logic [1:0]                           m_tuser
);
	import pee_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int DW = ((VALUE_WIDTH + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CALC  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t                state_q;
	logic signed [VW-1:0]  sum_q;
	logic signed [VW-1:0]  pend_q;
	logic                  pend_sub_q;
	pend_t                 pend_op_q;
	logic                  ovf_q;
	logic                  dbz_q;
	logic [2:0]            op_q;
	logic signed [VW-1:0]  term_q;
	logic                  m_tvalid_q;
	logic [VW-1:0]         m_data_q;
	logic [1:0]            m_user_q;

	logic                  accept;
	logic signed [VW-1:0]  operand;
	md_cmd_t               md_cmd;
	md_sts_t               md_sts;
	logic [VW-1:0]         md_result;
	logic [VW:0]           sum_ext;
	logic                  add_ovf;
	logic signed [VW-1:0]  sum_next;
	logic                  is_prod;
	logic                  is_addsub;
	logic                  out_free;
	logic                  emit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign operand = s_tdata[VW-1:0];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = DW'(m_data_q);
	assign m_tuser = m_user_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		md_cmd.start = accept && ((pend_op_q == PEND_MUL) ||
			((pend_op_q == PEND_DIV) && (operand != '0)));
		md_cmd.div = (pend_op_q == PEND_DIV);
		if (pend_sub_q) begin
			sum_ext = {sum_q[VW-1], sum_q} - {term_q[VW-1], term_q};
		end else begin
			sum_ext = {sum_q[VW-1], sum_q} + {term_q[VW-1], term_q};
		end
		add_ovf = sum_ext[VW] ^ sum_ext[VW-1];
		if (add_ovf) begin
			sum_next = sum_ext[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end else begin
			sum_next = sum_ext[VW-1:0];
		end
		is_prod = (op_q == OP_MUL) || (op_q == OP_DIV);
		is_addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
		emit = (state_q == ST_APPLY) && !is_prod && !is_addsub && out_free;
	end

	pee_muldiv #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (md_cmd),
		.a     (pend_q),
		.b     (operand),
		.sts   (md_sts),
		.result(md_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
			pend_q <= '0;
			pend_sub_q <= 1'b0;
			pend_op_q <= PEND_NONE;
			ovf_q <= 1'b0;
			dbz_q <= 1'b0;
			op_q <= OP_ADD;
			term_q <= '0;
			m_tvalid_q <= 1'b0;
			m_data_q <= '0;
			m_user_q <= '0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= s_tuser;
						if (md_cmd.start) begin
							state_q <= ST_CALC;
						end else if (pend_op_q == PEND_DIV) begin
							term_q <= pend_q[VW-1] ? {1'b1, {(VW-1){1'b0}}}
								: {1'b0, {(VW-1){1'b1}}};
							dbz_q <= 1'b1;
							state_q <= ST_APPLY;
						end else begin
							term_q <= operand;
							state_q <= ST_APPLY;
						end
					end
				end
				ST_CALC: begin
					if (md_sts.done) begin
						term_q <= md_result;
						ovf_q <= ovf_q | md_sts.ovf;
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					priority if (is_prod) begin
						pend_q <= term_q;
						pend_op_q <= (op_q == OP_MUL) ? PEND_MUL : PEND_DIV;
						state_q <= ST_IDLE;
					end else if (is_addsub) begin
						sum_q <= sum_next;
						ovf_q <= ovf_q | add_ovf;
						pend_sub_q <= (op_q == OP_SUB);
						pend_op_q <= PEND_NONE;
						pend_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						if (out_free) begin
							m_data_q <= sum_next;
							m_user_q <= {dbz_q, ovf_q | add_ovf};
							sum_q <= '0;
							pend_q <= '0;
							pend_sub_q <= 1'b0;
							pend_op_q <= PEND_NONE;
							ovf_q <= 1'b0;
							dbz_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
